/* hdl/cgr_pkg.sv */
// Shared types, constants and helper functions for the crossfade gain ramp.
// Used by cgr_ramp, crossfade_gain_ramp and the testbench; no dependencies.
package cgr_pkg;

  localparam int GAIN_W  = 16;
  localparam int SPEED_W = 24;
  localparam int DT_W    = 16;
  localparam int CFG_W   = 24;
  localparam int CFG_A_W = 2;
  localparam int PROD_W  = SPEED_W + DT_W;

  // Register indexes on the configuration port
  localparam logic [CFG_A_W-1:0] CFG_GAIN_FLOOR    = 2'd0;
  localparam logic [CFG_A_W-1:0] CFG_GAIN_CEIL     = 2'd1;
  localparam logic [CFG_A_W-1:0] CFG_EPSILON       = 2'd2;
  localparam logic [CFG_A_W-1:0] CFG_DEFAULT_SPEED = 2'd3;

  // Register and state reset values
  localparam logic [GAIN_W-1:0]  GAIN_FLOOR_RST    = 16'd0;
  localparam logic [GAIN_W-1:0]  GAIN_CEIL_RST     = 16'hFFFF;
  localparam logic [GAIN_W-1:0]  EPSILON_RST       = 16'd16;
  localparam logic [SPEED_W-1:0] DEFAULT_SPEED_RST = 24'd65535;

  // Step = min(floor(speed*dt/1000), 65535). A product at or above
  // 65535*1000+1000 saturates; below that, floor(p/1000) is
  // floor((p>>3)/125), and (p>>3) fits in 23 bits. Multiplying by
  // ceil(2^30/125) and shifting by 30 is exact over that range.
  localparam logic [PROD_W-1:0]  STEP_SAT_PROD = 40'd65536000;
  localparam int                 DIV_IN_W      = 23;
  localparam logic [23:0]        DIV125_MUL    = 24'd8589935;
  localparam int                 DIV125_SHIFT  = 30;
  localparam int                 DIV_PROD_W    = DIV_IN_W + 24;

  typedef enum logic [1:0] {
    KIND_TICK   = 2'd0,
    KIND_CONFIG = 2'd1,
    KIND_START  = 2'd2,
    KIND_STOP   = 2'd3
  } kind_t;

  typedef struct packed {
    kind_t               kind;
    logic [DT_W-1:0]     dt_ms;
    logic [GAIN_W-1:0]   from_level;
    logic [GAIN_W-1:0]   to_level;
    logic [SPEED_W-1:0]  rate;
  } in_item_t;

  typedef struct packed {
    logic [GAIN_W-1:0]   from_out;
    logic [GAIN_W-1:0]   to_out;
    logic                transitioning;
  } out_item_t;

  typedef struct packed {
    logic [GAIN_W-1:0]   gain_floor;
    logic [GAIN_W-1:0]   gain_ceil;
    logic [GAIN_W-1:0]   epsilon;
    logic [SPEED_W-1:0]  default_speed;
  } cgr_cfg_t;

  typedef struct packed {
    logic [GAIN_W-1:0]   current;
    logic [GAIN_W-1:0]   target;
    logic [SPEED_W-1:0]  speed;
  } ramp_t;

  // Below min wins over above max, also when min > max
  function automatic logic [GAIN_W-1:0] clamp_gain(
    input logic [GAIN_W-1:0] v,
    input cgr_cfg_t          cfg
  );
    logic [GAIN_W-1:0] r;
    if (v < cfg.gain_floor) begin
      r = cfg.gain_floor;
    end else if (v > cfg.gain_ceil) begin
      r = cfg.gain_ceil;
    end else begin
      r = v;
    end
    return r;
  endfunction

  function automatic logic [GAIN_W-1:0] gain_distance(input ramp_t r);
    logic [GAIN_W-1:0] d;
    if (r.target > r.current) begin
      d = r.target - r.current;
    end else begin
      d = r.current - r.target;
    end
    return d;
  endfunction

endpackage

/* hdl/cgr_ramp.sv */
// Next-state logic of one gain ramp for one operation.
// Depends on cgr_pkg (types, clamp and distance helpers, step constants).
module cgr_ramp
  import cgr_pkg::*;
(
  input  cgr_cfg_t            cfg,
  input  kind_t               kind,
  input  logic [DT_W-1:0]     dt_ms,
  input  logic [GAIN_W-1:0]   level,
  input  logic [GAIN_W-1:0]   fade_target,
  input  logic [SPEED_W-1:0]  rate,
  input  ramp_t               ramp_cur,
  output ramp_t               ramp_nxt,
  output logic                moving
);

  logic [PROD_W-1:0]     prod;
  logic [DIV_PROD_W-1:0] quot_prod;
  logic [GAIN_W-1:0]     step;
  logic [GAIN_W-1:0]     gap;
  logic [GAIN_W-1:0]     cur_clamped;

  // Step size: speed * dt / 1000, saturated
  assign prod      = PROD_W'(ramp_cur.speed) * PROD_W'(dt_ms);
  assign quot_prod = DIV_PROD_W'(prod[DIV_IN_W+2:3]) * DIV_PROD_W'(DIV125_MUL);
  assign step      = (prod >= STEP_SAT_PROD) ? {GAIN_W{1'b1}}
                                             : quot_prod[DIV125_SHIFT +: GAIN_W];

  assign gap         = gain_distance(ramp_cur);
  assign cur_clamped = clamp_gain(ramp_cur.current, cfg);

  // Apply the operation
  always_comb begin
    ramp_nxt = ramp_cur;
    unique case (kind)
      KIND_TICK: begin
        if (gap <= cfg.epsilon || gap <= step) begin
          // arrived or overshoot: land on target
          ramp_nxt.current = ramp_cur.target;
          ramp_nxt.speed   = '0;
        end else if (ramp_cur.target > ramp_cur.current) begin
          ramp_nxt.current = ramp_cur.current + step;
        end else begin
          ramp_nxt.current = ramp_cur.current - step;
        end
      end
      KIND_CONFIG: begin
        ramp_nxt.current = clamp_gain(level, cfg);
        ramp_nxt.target  = clamp_gain(level, cfg);
        ramp_nxt.speed   = '0;
      end
      KIND_START: begin
        ramp_nxt.target = clamp_gain(fade_target, cfg);
        ramp_nxt.speed  = (rate != '0) ? rate : cfg.default_speed;
      end
      KIND_STOP: begin
        ramp_nxt.current = cur_clamped;
        ramp_nxt.target  = cur_clamped;
        ramp_nxt.speed   = '0;
      end
      default: begin
        ramp_nxt = ramp_cur;
      end
    endcase
  end

  assign moving = gain_distance(ramp_nxt) > cfg.epsilon;

endmodule

/* hdl/crossfade_gain_ramp.sv */
// Top level of the crossfade gain ramp: config registers, input register,
// ramp state and result register. Depends on cgr_pkg and cgr_ramp.
//
//  channel | ports                          | moves
//  --------+--------------------------------+------------------------------
//  in      | in_valid, in_stall, in_data    | one operation per transfer
//  out     | out_valid, out_stall, out_data | both gains and transitioning
//  cfg     | cfg_we, cfg_addr, cfg_wdata    | one register write, no wait
//
// Each item goes from input transfer to result through the input register,
// then the ramp update loads the result register and the ramp state
// together. One item per cycle is sustained while the receiver does not
// stall; the ramp state loop (multiply, divide by 1000, compare, update)
// is combinational. Reset (synchronous, rst_n low) restores registers and
// ramp state. A stalled result holds, and the input register takes a new
// item when empty, or when the result register is free or being drained.
module crossfade_gain_ramp
  import cgr_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  in_item_t            in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output out_item_t           out_data,
  input  logic                cfg_we,
  input  logic [CFG_A_W-1:0]  cfg_addr,
  input  logic [CFG_W-1:0]    cfg_wdata
);

  cgr_cfg_t  cfg_r;
  logic      in_vld_r;
  in_item_t  in_item_r;
  logic      out_vld_r;
  out_item_t out_item_r;
  ramp_t     from_r;
  ramp_t     to_r;
  ramp_t     from_nxt;
  ramp_t     to_nxt;
  logic      from_moving;
  logic      to_moving;
  logic      advance;
  logic      in_take;

  // Move the held item into the result register when it is free or draining
  assign advance  = in_vld_r && (!out_vld_r || !out_stall);
  assign in_stall = in_vld_r && !advance;
  assign in_take  = in_valid && !in_stall;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.gain_floor    <= GAIN_FLOOR_RST;
      cfg_r.gain_ceil     <= GAIN_CEIL_RST;
      cfg_r.epsilon       <= EPSILON_RST;
      cfg_r.default_speed <= DEFAULT_SPEED_RST;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        CFG_GAIN_FLOOR:    cfg_r.gain_floor    <= cfg_wdata[GAIN_W-1:0];
        CFG_GAIN_CEIL:     cfg_r.gain_ceil     <= cfg_wdata[GAIN_W-1:0];
        CFG_EPSILON:       cfg_r.epsilon       <= cfg_wdata[GAIN_W-1:0];
        CFG_DEFAULT_SPEED: cfg_r.default_speed <= cfg_wdata[SPEED_W-1:0];
        default:           cfg_r               <= cfg_r;
      endcase
    end
  end

  // Input register: hold until advanced
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_take) begin
      in_vld_r <= 1'b1;
    end else if (advance) begin
      in_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      in_item_r <= in_data;
    end
  end

  // Ramp updates
  cgr_ramp u_from_ramp (
    .cfg         (cfg_r),
    .kind        (in_item_r.kind),
    .dt_ms       (in_item_r.dt_ms),
    .level       (in_item_r.from_level),
    .fade_target (cfg_r.gain_floor),
    .rate        (in_item_r.rate),
    .ramp_cur    (from_r),
    .ramp_nxt    (from_nxt),
    .moving      (from_moving)
  );

  cgr_ramp u_to_ramp (
    .cfg         (cfg_r),
    .kind        (in_item_r.kind),
    .dt_ms       (in_item_r.dt_ms),
    .level       (in_item_r.to_level),
    .fade_target (cfg_r.gain_ceil),
    .rate        (in_item_r.rate),
    .ramp_cur    (to_r),
    .ramp_nxt    (to_nxt),
    .moving      (to_moving)
  );

  // Ramp state: advance once per processed item
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      from_r.current <= GAIN_CEIL_RST;
      from_r.target  <= GAIN_CEIL_RST;
      from_r.speed   <= '0;
      to_r.current   <= GAIN_FLOOR_RST;
      to_r.target    <= GAIN_FLOOR_RST;
      to_r.speed     <= '0;
    end else if (advance) begin
      from_r <= from_nxt;
      to_r   <= to_nxt;
    end
  end

  // Result register: hold while stalled
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (advance) begin
      out_vld_r <= 1'b1;
    end else if (!out_stall) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_item_r.from_out      <= from_nxt.current;
      out_item_r.to_out        <= to_nxt.current;
      out_item_r.transitioning <= from_moving || to_moving;
    end
  end

  assign out_valid = out_vld_r;
  assign out_data  = out_item_r;

endmodule

/* test/cgr_gain_checker.sv */
// Checker for the crossfade gain ramp: watches the input, result and register
// ports, predicts both gains per operation and compares every result transfer.
// Depends on cgr_pkg for the payload, register and ramp types.
`timescale 1ns / 100ps

module cgr_gain_checker
  import cgr_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic                in_stall,
  input  in_item_t            in_data,
  input  logic                out_valid,
  input  logic                out_stall,
  input  out_item_t           out_data,
  input  logic                cfg_we,
  input  logic [CFG_A_W-1:0]  cfg_addr,
  input  logic [CFG_W-1:0]    cfg_wdata,
  output int                  fail_count,
  output int                  pending
);

  localparam int MAX_PRINTS = 40;

  cgr_cfg_t  regs;
  ramp_t     outgoing;
  ramp_t     incoming;
  out_item_t gains_due[$];
  out_item_t got;
  out_item_t want;
  int        n_fail = 0;
  int        n_due = 0;

  assign fail_count = n_fail;
  assign pending    = n_due;

  // Print one line per mismatch, keep counting past the print cap
  task automatic report_mismatch(input string what, input longint seen, input longint due);
    n_fail++;
    if (n_fail <= MAX_PRINTS) begin
      $display("%0t: result mismatch on %s: got %0d, expected %0d", $time, what, seen, due);
    end
  endtask

  // Clamp a gain: below min wins over above max
  function automatic logic [GAIN_W-1:0] bound_gain(input logic [GAIN_W-1:0] v);
    logic [GAIN_W-1:0] r;
    r = v;
    if (v < regs.gain_floor) begin
      r = regs.gain_floor;
    end else if (v > regs.gain_ceil) begin
      r = regs.gain_ceil;
    end
    return r;
  endfunction

  function automatic logic [GAIN_W-1:0] gap_to_target(input ramp_t r);
    logic [GAIN_W-1:0] d;
    if (r.target > r.current) begin
      d = r.target - r.current;
    end else begin
      d = r.current - r.target;
    end
    return d;
  endfunction

  // Set a ramp at rest on a clamped gain
  function automatic ramp_t park_ramp(input logic [GAIN_W-1:0] level);
    ramp_t r;
    r.current = bound_gain(level);
    r.target  = r.current;
    r.speed   = '0;
    return r;
  endfunction

  // Advance one ramp by speed*dt/1000, snapping when close or overshooting
  function automatic ramp_t advance_ramp(input ramp_t r, input logic [DT_W-1:0] dt);
    logic [GAIN_W-1:0] d;
    logic [63:0]       step;
    d = gap_to_target(r);
    if (d <= regs.epsilon) begin
      r.current = r.target;
      r.speed   = '0;
    end else if (r.speed != '0 && dt != '0) begin
      step = (64'(r.speed) * 64'(dt)) / 64'd1000;
      if (step > 64'd65535) begin
        step = 64'd65535;
      end
      if (64'(d) <= step) begin
        r.current = r.target;
        r.speed   = '0;
      end else if (r.target > r.current) begin
        r.current = r.current + step[GAIN_W-1:0];
      end else begin
        r.current = r.current - step[GAIN_W-1:0];
      end
    end
    return r;
  endfunction

  // Apply one operation to the predicted ramps and form the result
  task automatic apply_op(input in_item_t op, output out_item_t res);
    logic [SPEED_W-1:0] spd;
    case (op.kind)
      KIND_TICK: begin
        outgoing = advance_ramp(outgoing, op.dt_ms);
        incoming = advance_ramp(incoming, op.dt_ms);
      end
      KIND_CONFIG: begin
        outgoing = park_ramp(op.from_level);
        incoming = park_ramp(op.to_level);
      end
      KIND_START: begin
        spd = (op.rate != '0) ? op.rate : regs.default_speed;
        outgoing.target = bound_gain(regs.gain_floor);
        incoming.target = bound_gain(regs.gain_ceil);
        outgoing.speed  = spd;
        incoming.speed  = spd;
      end
      default: begin
        outgoing = park_ramp(outgoing.current);
        incoming = park_ramp(incoming.current);
      end
    endcase
    res.from_out      = outgoing.current;
    res.to_out        = incoming.current;
    res.transitioning = (gap_to_target(outgoing) > regs.epsilon) ||
                        (gap_to_target(incoming) > regs.epsilon);
  endtask

  // Track writes, check result transfers, then queue the prediction
  always @(posedge clk) begin
    if (!rst_n) begin
      regs.gain_floor    = GAIN_FLOOR_RST;
      regs.gain_ceil     = GAIN_CEIL_RST;
      regs.epsilon       = EPSILON_RST;
      regs.default_speed = DEFAULT_SPEED_RST;
      outgoing           = '{current: GAIN_CEIL_RST, target: GAIN_CEIL_RST, speed: '0};
      incoming           = '{current: GAIN_FLOOR_RST, target: GAIN_FLOOR_RST, speed: '0};
      gains_due.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_addr)
          CFG_GAIN_FLOOR:    regs.gain_floor    = cfg_wdata[GAIN_W-1:0];
          CFG_GAIN_CEIL:     regs.gain_ceil     = cfg_wdata[GAIN_W-1:0];
          CFG_EPSILON:       regs.epsilon       = cfg_wdata[GAIN_W-1:0];
          CFG_DEFAULT_SPEED: regs.default_speed = cfg_wdata[SPEED_W-1:0];
          default: ;
        endcase
      end
      if (out_valid && !out_stall) begin
        got = out_data;
        if (gains_due.size() == 0) begin
          report_mismatch("unexpected result transfer", 1, 0);
        end else begin
          want = gains_due.pop_front();
          if (got.from_out !== want.from_out) begin
            report_mismatch("from_out", got.from_out, want.from_out);
          end
          if (got.to_out !== want.to_out) begin
            report_mismatch("to_out", got.to_out, want.to_out);
          end
          if (got.transitioning !== want.transitioning) begin
            report_mismatch("transitioning", got.transitioning, want.transitioning);
          end
        end
      end
      if (in_valid && !in_stall) begin
        apply_op(in_data, want);
        gains_due.push_back(want);
      end
    end
    n_due = gains_due.size();
  end

endmodule

/* test/tb_crossfade_gain_ramp.sv */
// Testbench top for the crossfade gain ramp: clock, reset, register writes,
// operation stimulus and receiver stalls; checking lives in cgr_gain_checker.
// Depends on cgr_pkg, crossfade_gain_ramp and cgr_gain_checker.
`timescale 1ns / 100ps

module tb_crossfade_gain_ramp;
  import cgr_pkg::*;

  localparam int HOLD_CYCLES = 300;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  in_item_t           in_data = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  out_item_t          out_data;
  logic               cfg_we = 1'b0;
  logic [CFG_A_W-1:0] cfg_addr = '0;
  logic [CFG_W-1:0]   cfg_wdata = '0;

  int fail_count;
  int pending;
  int send_idle_pct = 0;
  int stall_pct = 0;
  int hold_req = 0;
  int hold_seen = 0;
  int hold_left = 0;

  crossfade_gain_ramp dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata)
  );

  cgr_gain_checker u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .fail_count (fail_count),
    .pending    (pending)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Hard stop if the run hangs
  initial begin
    #2_000_000;
    $display("FAIL");
    $finish;
  end

  // Receiver: random stalls, or a long hold-off when one is requested
  always @(negedge clk) begin
    if (hold_req != hold_seen) begin
      hold_seen <= hold_req;
      hold_left <= HOLD_CYCLES;
      out_stall <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  // Offer one operation and hold it until the transfer happens
  task automatic send_op(input in_item_t op);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(negedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    in_data  <= op;
    in_valid <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
  endtask

  // Fully random operation; the fields an operation ignores stay random
  function automatic in_item_t noise_op();
    in_item_t op;
    op.kind       = kind_t'($urandom_range(3));
    op.dt_ms      = DT_W'($urandom);
    op.from_level = GAIN_W'($urandom);
    op.to_level   = GAIN_W'($urandom);
    op.rate       = SPEED_W'($urandom);
    return op;
  endfunction

  task automatic op_tick(input int dt);
    in_item_t op;
    op       = noise_op();
    op.kind  = KIND_TICK;
    op.dt_ms = DT_W'(dt);
    send_op(op);
  endtask

  task automatic op_config(input int from_lvl, input int to_lvl);
    in_item_t op;
    op            = noise_op();
    op.kind       = KIND_CONFIG;
    op.from_level = GAIN_W'(from_lvl);
    op.to_level   = GAIN_W'(to_lvl);
    send_op(op);
  endtask

  task automatic op_start(input int spd);
    in_item_t op;
    op      = noise_op();
    op.kind = KIND_START;
    op.rate = SPEED_W'(spd);
    send_op(op);
  endtask

  task automatic op_stop();
    in_item_t op;
    op      = noise_op();
    op.kind = KIND_STOP;
    send_op(op);
  endtask

  // Drop valid and let every expected result drain before touching registers
  task automatic settle();
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_regs(input int lo_g, input int hi_g, input int eps, input int dspd);
    cfg_we    <= 1'b1;
    cfg_addr  <= CFG_GAIN_FLOOR;
    cfg_wdata <= CFG_W'(lo_g);
    @(negedge clk);
    cfg_addr  <= CFG_GAIN_CEIL;
    cfg_wdata <= CFG_W'(hi_g);
    @(negedge clk);
    cfg_addr  <= CFG_EPSILON;
    cfg_wdata <= CFG_W'(eps);
    @(negedge clk);
    cfg_addr  <= CFG_DEFAULT_SPEED;
    cfg_wdata <= CFG_W'(dspd);
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  function automatic int pick_rate();
    int r;
    case ($urandom_range(9))
      0:          r = 0;
      1, 2, 3, 4: r = $urandom_range(1, 3000);
      5, 6, 7:    r = $urandom_range(3000, 300000);
      8:          r = int'(SPEED_W'($urandom));
      default:    r = 24'hFFFFFF;
    endcase
    return r;
  endfunction

  function automatic int pick_dt();
    int d;
    case ($urandom_range(9))
      0:                d = 0;
      1, 2, 3, 4, 5, 6: d = $urandom_range(1, 64);
      7, 8:             d = $urandom_range(65, 2000);
      default:          d = int'(DT_W'($urandom));
    endcase
    return d;
  endfunction

  function automatic int pick_level();
    int l;
    case ($urandom_range(9))
      0:       l = 0;
      1:       l = 65535;
      default: l = int'(GAIN_W'($urandom));
    endcase
    return l;
  endfunction

  // Mostly whole fades (configure, start, ticks, maybe stop), some noise
  task automatic run_fades(input int n_ops);
    int sent;
    int n_ticks;
    sent = 0;
    while (sent < n_ops) begin
      if ($urandom_range(99) < 12) begin
        send_op(noise_op());
        sent++;
      end else begin
        if ($urandom_range(3) != 0) begin
          op_config(pick_level(), pick_level());
          sent++;
        end
        op_start(pick_rate());
        n_ticks = $urandom_range(1, 8);
        repeat (n_ticks) op_tick(pick_dt());
        sent += n_ticks + 1;
        if ($urandom_range(3) == 0) begin
          op_stop();
          op_tick(pick_dt());
          sent += 2;
        end
      end
    end
  endtask

  task automatic set_idling(input int send_pct, input int stall);
    send_idle_pct = send_pct;
    stall_pct    <= stall;
  endtask

  initial begin
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed: reset values, defaults, step edge cases
    op_tick(0);
    op_start(0);
    op_tick(0);
    op_tick(1);
    op_stop();
    op_start(1);
    op_tick(1);
    op_tick(999);
    op_tick(1000);
    op_start(24'hFFFFFF);
    op_tick(65535);
    op_config(0, 65535);
    op_config(65535, 0);
    op_start(0);
    op_tick(65535);
    op_config(30000, 30010);
    op_start(500);
    op_tick(10);

    // Directed: clamping, zero default speed, zero epsilon
    settle();
    write_regs(1000, 60000, 0, 0);
    op_config(0, 65535);
    op_start(0);
    op_tick(100);
    op_start(7);
    op_tick(1000);
    op_stop();

    // Directed: min above max, stop re-clamps under the new registers
    settle();
    write_regs(50000, 10000, 16, 65535);
    op_config(20000, 60000);
    op_stop();

    // Full range registers, no idling, one long receiver hold-off
    settle();
    write_regs(0, 65535, 0, 24'hFFFFFF);
    set_idling(0, 0);
    run_fades(75);
    hold_req <= hold_req + 1;
    run_fades(30);
    run_fades(75);

    // Random window, sender mostly idle
    settle();
    write_regs($urandom_range(0, 20000), $urandom_range(40000, 65535),
               $urandom_range(0, 200), $urandom_range(1, 2000000));
    set_idling(81, 0);
    run_fades(150);

    // Reset-value registers, receiver mostly stalling
    settle();
    write_regs(GAIN_FLOOR_RST, GAIN_CEIL_RST, EPSILON_RST, DEFAULT_SPEED_RST);
    set_idling(0, 81);
    run_fades(150);

    // Any order of min and max, both sides idling now and then
    settle();
    write_regs(int'(GAIN_W'($urandom)), int'(GAIN_W'($urandom)),
               $urandom_range(0, 64), $urandom_range(0, 500000));
    set_idling(23, 23);
    run_fades(150);

    // Extremes: inverted window, widest epsilon, zero default speed
    settle();
    write_regs(50000, 10000, 65535, 0);
    set_idling(0, 0);
    run_fades(60);

    settle();
    repeat (6) @(negedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
